// File: hw/rtl/sync_framed_command_parser_macros.svh
// Assertion helpers used by the parser RTL.
`ifndef SYNC_FRAMED_COMMAND_PARSER_MACROS_SVH
`define SYNC_FRAMED_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SFCP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfcp: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SFCP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfcp: next-cycle check failed");

`endif

// File: hw/rtl/sfcp_pkg.sv
`default_nettype none

package sfcp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned CMP_W      = 15;
    localparam int unsigned M_DATA_W   = 64;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;
    localparam logic [BYTE_W-1:0] FRAME_END   = 8'hFF;

    localparam int unsigned           PAYLOAD_LEN   = 6;
    localparam logic [IDX_W-1:0]      PAYLOAD_COUNT = 3'd6;
    localparam logic [IDX_W-1:0]      PAYLOAD_LAST  = 3'd5;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_DATA  = 2'd2,
        PH_END   = 2'd3
    } phase_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

// File: hw/rtl/sync_framed_command_parser.sv
// Sync-framed command parser. Takes one received byte per s_ transaction,
// hunts for the sync pair A5 5A, gathers six payload bytes as plain data, and
// checks the following terminator slot: FF accepts the frame and emits one
// m_ transaction, A5 restarts the sync at its second byte, anything else drops
// the frame. The payload reads big-endian as period, prescaler and sample
// count; the result carries period-1 and prescaler-1 (both wrap at zero),
// period>>1 as a PWM compare value, and the unchecked sample count. Timing:
// one byte per clock sustained while results drain; a byte is held in the input
// register until the state update consumes it, and a frame's result is loaded
// into the output register that drives m_tvalid. The input side keeps
// accepting while a finished result waits in the output register, and only
// stalls when that register is full and a byte is waiting to be processed.
`default_nettype none
`include "sync_framed_command_parser_macros.svh"

module sync_framed_command_parser (
    input  wire  logic                              aclk,
    input  wire  logic                              aresetn,
    input  wire  logic                              s_tvalid,
    output logic                                    s_tready,
    input  wire  logic [sfcp_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] rx_byte
    output logic                                    m_tvalid,
    input  wire  logic                              m_tready,
    // [15:0] timer_reload, [31:16] timer_prescale, [46:32] compare_pulse,
    // [62:47] sample_count, [63] zero
    output logic [sfcp_pkg::M_DATA_W-1:0]           m_tdata
);
    import sfcp_pkg::*;

    // Input register: holds one byte until the state update consumes it.
    logic              in_valid_reg, in_valid_next;
    byte_t             in_byte_reg;

    // Parser state.
    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    byte_t             store_reg [PAYLOAD_LEN];

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic              s_accept;
    logic              out_free;
    logic              fire;
    logic              store_wr_en;
    logic [IDX_W-1:0]  idx_clamp;
    logic [IDX_W-1:0]  idx_inc;
    logic              result_load;
    logic [HALF_W-1:0] period;
    logic [HALF_W-1:0] prescale;
    logic [HALF_W-1:0] samples;

    // The output slot can take a new result when empty or draining now.
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Clamp the slot pointer to the last slot; it never passes it in practice.
    assign idx_clamp = (idx_reg >= PAYLOAD_COUNT) ? PAYLOAD_LAST : idx_reg;
    assign idx_inc   = idx_clamp + 3'd1;

    assign period   = {store_reg[0], store_reg[1]};
    assign prescale = {store_reg[2], store_reg[3]};
    assign samples  = {store_reg[4], store_reg[5]};

    // Next-state logic.
    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (in_byte_reg == SYNC_FIRST) phase_next = PH_SYNC2;
                end
                PH_SYNC2: begin
                    if (in_byte_reg == SYNC_SECOND)     phase_next = PH_DATA;
                    else if (in_byte_reg == SYNC_FIRST) phase_next = PH_SYNC2;
                    else                                phase_next = PH_HUNT;
                end
                PH_DATA: begin
                    if (idx_inc >= PAYLOAD_COUNT) phase_next = PH_END;
                end
                PH_END: begin
                    // Terminator slot: accept, restart sync, or drop.
                    if (in_byte_reg == SYNC_FIRST) phase_next = PH_SYNC2;
                    else                           phase_next = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // Output and datapath control.
    always_comb begin
        store_wr_en = 1'b0;
        result_load = 1'b0;
        idx_next    = idx_reg;
        if (fire) begin
            unique case (phase_reg)
                PH_DATA: begin
                    store_wr_en = 1'b1;
                    idx_next    = (idx_inc >= PAYLOAD_COUNT) ? '0 : idx_inc;
                end
                PH_END: begin
                    result_load = (in_byte_reg == FRAME_END);
                end
                default: begin
                    idx_next = idx_reg;
                end
            endcase
        end
    end

    // Result fields, packed highest field first.
    always_comb begin
        m_data_next = {1'b0, samples, period[HALF_W-1:1],
                       prescale - 16'd1, period - 16'd1};
        if (result_load)   m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
        else               m_valid_next = m_valid_reg;
    end

    always_comb begin
        if (s_accept)  in_valid_next = 1'b1;
        else if (fire) in_valid_next = 1'b0;
        else           in_valid_next = in_valid_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HUNT;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_accept) in_byte_reg <= s_tdata;
        if (store_wr_en) store_reg[idx_clamp] <= in_byte_reg;
        if (result_load) m_data_reg <= m_data_next;
    end

    // Slot pointer stays within the payload.
    `SFCP_ASSERT_NOW(a_idx_in_range, aclk, aresetn, 1'b1, idx_reg < PAYLOAD_COUNT)
    // Pointer rests at zero outside payload collection.
    `SFCP_ASSERT_NOW(a_idx_idle, aclk, aresetn, phase_reg != PH_DATA, idx_reg == '0)
    // A fresh result only follows a byte taken in the terminator slot.
    `SFCP_ASSERT_NOW(a_result_from_end, aclk, aresetn, $rose(m_valid_reg),
        $past(phase_reg) == PH_END && $past(in_byte_reg) == FRAME_END)

endmodule

`default_nettype wire

// File: tb/sv/sync_framed_command_parser_tb.sv
`default_nettype none

import sfcp_pkg::*;

// Result layout on m_tdata, highest field first so the packed struct overlays the bus.
typedef struct packed {
    logic                pad;
    logic [HALF_W-1:0]   sample_count;
    logic [CMP_W-1:0]    compare_pulse;
    logic [HALF_W-1:0]   timer_prescale;
    logic [HALF_W-1:0]   timer_reload;
} timer_setup_t;

class frame_scoreboard;
    phase_t             phase;
    logic [IDX_W-1:0]   slot;
    byte_t              payload [PAYLOAD_LEN];
    timer_setup_t       pending_setups [$];
    int unsigned        frames_checked;
    int unsigned        term_restarts;
    int unsigned        term_drops;
    int unsigned        errors;

    function new();
        phase          = PH_HUNT;
        slot           = '0;
        frames_checked = 0;
        term_restarts  = 0;
        term_drops     = 0;
        errors         = 0;
        foreach (payload[i]) payload[i] = '0;
    endfunction

    // Advance the frame state by one accepted byte; queue a setup when a frame closes.
    function void note_byte(byte_t b);
        timer_setup_t       setup;
        logic [HALF_W-1:0]  period;
        logic [HALF_W-1:0]  prescale;
        logic [IDX_W-1:0]   idx;
        case (phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND)     phase = PH_DATA;
                else if (b == SYNC_FIRST) phase = PH_SYNC2;
                else                      phase = PH_HUNT;
            end
            PH_DATA: begin
                idx = slot;
                if (idx >= PAYLOAD_COUNT) idx = PAYLOAD_LAST;
                payload[idx] = b;
                if (idx == PAYLOAD_LAST) begin
                    phase = PH_END;
                    slot  = '0;
                end else begin
                    slot = idx + 1'b1;
                end
            end
            default: begin
                if (b == FRAME_END) begin
                    period               = {payload[0], payload[1]};
                    prescale             = {payload[2], payload[3]};
                    setup.pad            = 1'b0;
                    setup.timer_reload   = period - 1'b1;
                    setup.timer_prescale = prescale - 1'b1;
                    setup.compare_pulse  = period[HALF_W-1:1];
                    setup.sample_count   = {payload[4], payload[5]};
                    pending_setups.push_back(setup);
                    phase = PH_HUNT;
                end else if (b == SYNC_FIRST) begin
                    term_restarts++;
                    phase = PH_SYNC2;
                end else begin
                    term_drops++;
                    phase = PH_HUNT;
                end
            end
        endcase
    endfunction

    function void compare_field(string name, logic [HALF_W-1:0] want, logic [HALF_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Check one result transaction against the oldest queued setup.
    function void check_result(logic [M_DATA_W-1:0] data);
        timer_setup_t got;
        timer_setup_t want;
        got = data;
        if (pending_setups.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, data);
        end else begin
            want = pending_setups.pop_front();
            frames_checked++;
            compare_field("timer_reload", want.timer_reload, got.timer_reload);
            compare_field("timer_prescale", want.timer_prescale, got.timer_prescale);
            compare_field("compare_pulse", {{(HALF_W-CMP_W){1'b0}}, want.compare_pulse},
                          {{(HALF_W-CMP_W){1'b0}}, got.compare_pulse});
            compare_field("sample_count", want.sample_count, got.sample_count);
            compare_field("pad", {{(HALF_W-1){1'b0}}, want.pad},
                          {{(HALF_W-1){1'b0}}, got.pad});
        end
    endfunction
endclass

module sync_framed_command_parser_tb;

    localparam int unsigned RANDOM_BYTES = 1250;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 400;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    byte_t                  s_tdata  = '0;    // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [15:0] timer_reload, [31:16] timer_prescale, [46:32] compare_pulse,
    // [62:47] sample_count, [63] zero
    logic [M_DATA_W-1:0]    m_tdata;

    frame_scoreboard        parser_sb = new();

    int unsigned            send_idle_pct = 0;
    int unsigned            recv_idle_pct = 0;
    int unsigned            hold_request  = 0;
    int unsigned            frame_bytes   = 0;
    int unsigned            bytes_sent    = 0;
    int unsigned            cycle_count   = 0;

    // Directed opening: zero period and prescaler (both wrap), a repeated first
    // sync byte, payload bytes that look like sync and terminator codes, a
    // terminator slot holding the first sync byte that restarts the sync, and
    // all-ones fields.
    byte_t directed_bytes [] = '{
        8'h13, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, FRAME_END,
        SYNC_FIRST, SYNC_SECOND,
        FRAME_END, FRAME_END, SYNC_FIRST, SYNC_SECOND, FRAME_END, FRAME_END,
        SYNC_FIRST,
        SYNC_SECOND, 8'h00, 8'h01, FRAME_END, FRAME_END, SYNC_SECOND, SYNC_FIRST, FRAME_END
    };

    sync_framed_command_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Offer one byte, idling first at the current rate, and hold it until the
    // input transaction completes; then hand it to the scoreboard.
    task automatic send_byte(input byte_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        parser_sb.note_byte(b);
        bytes_sent++;
    endtask

    // Emit one chunk of random traffic: mostly well-formed frames with random
    // payload, plus noise and broken sync pairs.
    task automatic send_traffic_chunk();
        int unsigned kind;
        int unsigned pick;
        byte_t       b;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // Drop a few bytes of line noise; the hunt ignores most of them.
            repeat ($urandom_range(3, 1)) send_byte(byte_t'($urandom_range(255)));
        end else if (kind < 16) begin
            // Break the sync pair after its first byte.
            send_byte(SYNC_FIRST);
            send_byte(byte_t'($urandom_range(255)));
            frame_bytes += 2;
        end else begin
            send_byte(SYNC_FIRST);
            if ($urandom_range(9) == 0) send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            repeat (PAYLOAD_LEN) begin
                // Bias payload toward codes and field extremes.
                pick = $urandom_range(99);
                if (pick < 6)       b = 8'h00;
                else if (pick < 12) b = FRAME_END;
                else if (pick < 16) b = SYNC_FIRST;
                else if (pick < 20) b = SYNC_SECOND;
                else if (pick < 23) b = 8'h01;
                else                b = byte_t'($urandom_range(255));
                send_byte(b);
            end
            pick = $urandom_range(99);
            if (pick < 72)      send_byte(FRAME_END);
            else if (pick < 84) send_byte(SYNC_FIRST);
            else                send_byte(byte_t'($urandom_range(255)));
            frame_bytes += 9;
        end
    endtask

    // Receiver: check every result transaction, stall at the current rate, and
    // honor a long hold-off counted here.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) parser_sb.check_result(m_tdata);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_stop;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 15;
        recv_idle_pct = 69;
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

        // Sender idles lightly, receiver heavily.
        phase_stop = RANDOM_BYTES / 3;
        while (frame_bytes < phase_stop) send_traffic_chunk();

        // Swap the idle rates.
        send_idle_pct = 69;
        recv_idle_pct = 15;
        phase_stop    = 2 * RANDOM_BYTES / 3;
        while (frame_bytes < phase_stop) send_traffic_chunk();

        // No idling; a long receiver hold-off first so results back up and
        // the parser stalls its input while bytes keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        while (frame_bytes < RANDOM_BYTES) send_traffic_chunk();

        s_tvalid <= 1'b0;
        while (parser_sb.pending_setups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input bytes and %0d checked frames across three idle mixes;",
                 bytes_sent, parser_sb.frames_checked);
        $display("terminator slot restarted the sync %0d times and dropped %0d frames.",
                 parser_sb.term_restarts, parser_sb.term_drops);
        if (parser_sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/sfcp_pkg.sv
hw/rtl/sync_framed_command_parser.sv
tb/sv/sync_framed_command_parser_tb.sv
